FILE: rtl/core/bcp_pkg.sv
// shared types and constants of the binomial call option pricer
`timescale 1ns / 1ps

package bcp_pkg;

   // lattice depth default
   localparam int STEPS_DEFAULT = 64;

   // field widths
   localparam int PRICE_W = 32;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   // register indexes
   localparam logic [1:0] REG_LOWEST_PRICE_FACTOR = 2'd0;
   localparam logic [1:0] REG_UP_SQUARED          = 2'd1;
   localparam logic [1:0] REG_WEIGHT_UP           = 2'd2;
   localparam logic [1:0] REG_WEIGHT_DOWN         = 2'd3;

   // register reset values
   localparam logic [31:0] RST_LOWEST_PRICE_FACTOR = 32'hFFFF_FFFF;
   localparam logic [31:0] RST_UP_SQUARED          = 32'h1000_0000;
   localparam logic [31:0] RST_WEIGHT_UP           = 32'h8000_0000;
   localparam logic [31:0] RST_WEIGHT_DOWN         = 32'h8000_0000;

   // rounding offsets
   localparam logic [63:0] HALF_Q32 = 64'h0000_0000_8000_0000;
   localparam logic [63:0] HALF_Q28 = 64'h0000_0000_0800_0000;

   // control of the price generator
   typedef struct packed {
      logic capture;
      logic seed;
      logic step;
   } gen_ctrl_type;

   // control of the node cells
   typedef struct packed {
      logic load;
      logic mul;
      logic add;
   } cell_ctrl_type;

endpackage

FILE: rtl/core/binomial_call_option_pricer.sv
// top level of the binomial call option pricer: sequencer, registers, price generator, node chain
//
//   channel   direction  handshake                   payload
//   request   in         start high, busy low        req_spot_price, req_strike_price
//   result    out        rsp_valid for one cycle     rsp_option_value, rsp_overflow
//   csr       in/out     psel, penable, pwrite       paddr, pwdata, prdata
//
// an item runs through these steps before the next item can be accepted: the
// price generator seeds the lowest price and the terminal payoffs are shifted
// in through it, then each lattice level does the multiply and then the rounded
// add in every node cell; then the result is shown and the sequencer idles again.
// busy is high from the cycle after the accept through the result cycle.
// reset restores the register defaults and idles the sequencer; node contents
// are left as they are. the receiver takes the result in its single valid cycle.
`timescale 1ns / 1ps

module binomial_call_option_pricer #(
   parameter int STEPS = bcp_pkg::STEPS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [bcp_pkg::PRICE_W-1:0]   req_spot_price,
   input  logic [bcp_pkg::PRICE_W-1:0]   req_strike_price,
   output logic                          rsp_valid,
   output logic [bcp_pkg::PRICE_W-1:0]   rsp_option_value,
   output logic                          rsp_overflow,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bcp_pkg::CSR_AW-1:0]    paddr,
   input  logic [bcp_pkg::CSR_DW-1:0]    pwdata,
   output logic [bcp_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready
);

   localparam int CNT_W = $clog2(STEPS + 2);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_GEN  = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_ADD  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             gen_ovf_ff, gen_ovf_in;

   logic [31:0] lowest_price_factor_ff, lowest_price_factor_in;
   logic [31:0] up_squared_ff, up_squared_in;
   logic [31:0] weight_up_ff, weight_up_in;
   logic [31:0] weight_down_ff, weight_down_in;

   bcp_pkg::gen_ctrl_type  gen_ctrl;
   bcp_pkg::cell_ctrl_type cell_ctrl;
   logic [bcp_pkg::PRICE_W-1:0] payoff;
   logic                        step_sat;
   logic                        accept;
   logic                        csr_write;
   logic [1:0]                  csr_index;

   logic [bcp_pkg::PRICE_W-1:0] node_value [STEPS+1];
   logic                        node_flag  [STEPS+1];

   assign accept    = start && !busy;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[3:2];
   assign pready    = 1'b1;

   // configuration registers
   always_comb begin
      lowest_price_factor_in = lowest_price_factor_ff;
      up_squared_in          = up_squared_ff;
      weight_up_in           = weight_up_ff;
      weight_down_in         = weight_down_ff;
      if (csr_write) begin
         case (csr_index)
            bcp_pkg::REG_LOWEST_PRICE_FACTOR: lowest_price_factor_in = pwdata;
            bcp_pkg::REG_UP_SQUARED:          up_squared_in          = pwdata;
            bcp_pkg::REG_WEIGHT_UP:           weight_up_in           = pwdata;
            bcp_pkg::REG_WEIGHT_DOWN:         weight_down_in         = pwdata;
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_index)
         bcp_pkg::REG_LOWEST_PRICE_FACTOR: prdata = lowest_price_factor_ff;
         bcp_pkg::REG_UP_SQUARED:          prdata = up_squared_ff;
         bcp_pkg::REG_WEIGHT_UP:           prdata = weight_up_ff;
         bcp_pkg::REG_WEIGHT_DOWN:         prdata = weight_down_ff;
         default:                          prdata = '0;
      endcase
   end

   // sequencer: generate and shift, then multiply / add per level
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      gen_ovf_in = gen_ovf_ff;
      gen_ctrl   = '0;
      cell_ctrl  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               gen_ctrl.capture = 1'b1;
               gen_ovf_in       = 1'b0;
               cnt_in           = '0;
               state_in         = ST_GEN;
            end
         end
         ST_GEN: begin
            if (cnt_ff == '0) begin
               gen_ctrl.seed = 1'b1;
               cnt_in        = cnt_ff + 1'b1;
            end else begin
               gen_ctrl.step  = 1'b1;
               cell_ctrl.load = 1'b1;
               if (cnt_ff <= CNT_W'(STEPS)) begin
                  gen_ovf_in = gen_ovf_ff | step_sat;
               end
               if (cnt_ff == CNT_W'(STEPS + 1)) begin
                  cnt_in   = CNT_W'(STEPS - 1);
                  state_in = ST_MUL;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_MUL: begin
            cell_ctrl.mul = 1'b1;
            state_in      = ST_ADD;
         end
         ST_ADD: begin
            cell_ctrl.add = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in   = cnt_ff - 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff               <= ST_IDLE;
         cnt_ff                 <= '0;
         lowest_price_factor_ff <= bcp_pkg::RST_LOWEST_PRICE_FACTOR;
         up_squared_ff          <= bcp_pkg::RST_UP_SQUARED;
         weight_up_ff           <= bcp_pkg::RST_WEIGHT_UP;
         weight_down_ff         <= bcp_pkg::RST_WEIGHT_DOWN;
      end else begin
         state_ff               <= state_in;
         cnt_ff                 <= cnt_in;
         lowest_price_factor_ff <= lowest_price_factor_in;
         up_squared_ff          <= up_squared_in;
         weight_up_ff           <= weight_up_in;
         weight_down_ff         <= weight_down_in;
      end
      gen_ovf_ff <= gen_ovf_in;
   end

   // terminal price generator
   bcp_price_gen u_price_gen (
      .clock               (clock),
      .ctrl                (gen_ctrl),
      .spot                (req_spot_price),
      .strike              (req_strike_price),
      .lowest_price_factor (lowest_price_factor_ff),
      .up_squared          (up_squared_ff),
      .payoff              (payoff),
      .step_sat            (step_sat)
   );

   // node chain, payoffs enter at the top cell
   for (genvar i = 0; i <= STEPS; i++) begin : g_node
      logic [bcp_pkg::PRICE_W-1:0] upper_value;
      logic                        upper_flag;
      logic                        live;

      if (i == STEPS) begin : g_top
         assign upper_value = payoff;
         assign upper_flag  = 1'b0;
      end else begin : g_mid
         assign upper_value = node_value[i+1];
         assign upper_flag  = node_flag[i+1];
      end

      // cell i holds a real node while the level index is at least i
      assign live = (cnt_ff >= CNT_W'(i));

      bcp_node_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .live        (live),
         .weight_up   (weight_up_ff),
         .weight_down (weight_down_ff),
         .upper_value (upper_value),
         .upper_flag  (upper_flag),
         .value       (node_value[i]),
         .flag        (node_flag[i])
      );
   end

   // result and status
   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = (state_ff == ST_DONE);
   assign rsp_option_value = node_value[0];
   assign rsp_overflow     = gen_ovf_ff | node_flag[0];

endmodule

FILE: rtl/core/bcp_price_gen.sv
// terminal price generator: lowest price, then repeated scaling by u squared
`timescale 1ns / 1ps

module bcp_price_gen (
   input  logic                          clock,
   input  bcp_pkg::gen_ctrl_type         ctrl,
   input  logic [bcp_pkg::PRICE_W-1:0]   spot,
   input  logic [bcp_pkg::PRICE_W-1:0]   strike,
   input  logic [31:0]                   lowest_price_factor,
   input  logic [31:0]                   up_squared,
   output logic [bcp_pkg::PRICE_W-1:0]   payoff,
   output logic                          step_sat
);

   logic [bcp_pkg::PRICE_W-1:0] spot_ff, spot_in;
   logic [bcp_pkg::PRICE_W-1:0] strike_ff, strike_in;
   logic [bcp_pkg::PRICE_W-1:0] price_ff, price_in;
   logic [63:0] lowest_prod;
   logic [63:0] next_prod;

   // lowest price and next price products, rounded half up
   assign lowest_prod = {32'd0, spot_ff} * {32'd0, lowest_price_factor} + bcp_pkg::HALF_Q32;
   assign next_prod   = {32'd0, price_ff} * {32'd0, up_squared} + bcp_pkg::HALF_Q28;
   assign step_sat    = (next_prod[63:60] != 4'd0);

   always_comb begin
      spot_in   = spot_ff;
      strike_in = strike_ff;
      price_in  = price_ff;
      if (ctrl.capture) begin
         spot_in   = spot;
         strike_in = strike;
      end
      if (ctrl.seed) begin
         price_in = lowest_prod[63:32];
      end else if (ctrl.step) begin
         price_in = step_sat ? '1 : next_prod[59:28];
      end
   end

   always_ff @(posedge clock) begin
      spot_ff   <= spot_in;
      strike_ff <= strike_in;
      price_ff  <= price_in;
   end

   // call payoff of the current terminal node
   assign payoff = (price_ff > strike_ff) ? (price_ff - strike_ff) : '0;

endmodule

FILE: rtl/core/bcp_node_cell.sv
// one lattice node: shifts payoffs in, then folds with its upper neighbor
`timescale 1ns / 1ps

module bcp_node_cell (
   input  logic                          clock,
   input  bcp_pkg::cell_ctrl_type        ctrl,
   input  logic                          live,
   input  logic [31:0]                   weight_up,
   input  logic [31:0]                   weight_down,
   input  logic [bcp_pkg::PRICE_W-1:0]   upper_value,
   input  logic                          upper_flag,
   output logic [bcp_pkg::PRICE_W-1:0]   value,
   output logic                          flag
);

   logic [bcp_pkg::PRICE_W-1:0] value_ff, value_in;
   logic [63:0] prod_up_ff, prod_up_in;
   logic [63:0] prod_dn_ff, prod_dn_in;
   logic        flag_ff, flag_in;
   logic [65:0] sum;
   logic        sat;

   // weighted sum of both children, rounded half up
   assign sum = {2'd0, prod_up_ff} + {2'd0, prod_dn_ff} + {2'd0, bcp_pkg::HALF_Q32};
   assign sat = (sum[65:64] != 2'd0);

   always_comb begin
      value_in   = value_ff;
      prod_up_in = prod_up_ff;
      prod_dn_in = prod_dn_ff;
      flag_in    = flag_ff;
      if (ctrl.load) begin
         value_in = upper_value;
         flag_in  = 1'b0;
      end
      if (ctrl.mul) begin
         prod_up_in = {32'd0, weight_up} * {32'd0, upper_value};
         prod_dn_in = {32'd0, weight_down} * {32'd0, value_ff};
      end
      if (ctrl.add) begin
         value_in = sat ? '1 : sum[63:32];
         // saturation flags drift down toward the root one level at a time
         flag_in  = flag_ff | upper_flag | (sat & live);
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      prod_up_ff <= prod_up_in;
      prod_dn_ff <= prod_dn_in;
      flag_ff    <= flag_in;
   end

   assign value = value_ff;
   assign flag  = flag_ff;

endmodule

FILE: rtl/core/bcp_checker.sv
// port-level checks of the binomial call option pricer and their bind
`timescale 1ns / 1ps

module bcp_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic pready
);

   // an accepted item makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // a result is only shown while busy
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result shown while not busy");

   // one result cycle per item, then the block is free again
   a_valid_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result strobe longer than one cycle");

   // busy drops only right after the result
   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      (busy && !rsp_valid) |=> busy)
      else $error("busy dropped without a result");

   a_pready: assert property (@(posedge clock) pready)
      else $error("pready low");

endmodule

bind binomial_call_option_pricer bcp_checker u_bcp_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .pready    (pready)
);
